[hdl/turret_mode_controller_core_defines.svh]
// assertion helpers for the turret mode controller
`ifndef TURRET_MODE_CONTROLLER_CORE_DEFINES_SVH
`define TURRET_MODE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TMC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tmc_pkg.sv]
package tmc_pkg;

	localparam int SINE_ENTRIES = 256;
	localparam int SINE_IDX_W = $clog2(SINE_ENTRIES);
	localparam logic [7:0] BURST_RATE = 8'd20;

	localparam int IN_TDATA_W = 120;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		MODE_PATROL = 3'd0,
		MODE_TRACK = 3'd1,
		MODE_ATTACK = 3'd2,
		MODE_DEFEND = 3'd3,
		MODE_STOP = 3'd4
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_YAW_LOW = 3'd0,
		REG_YAW_HIGH = 3'd1,
		REG_SWEEP_RATE = 3'd2,
		REG_PATROL_TILT = 3'd3,
		REG_RANGE_LIMIT = 3'd4,
		REG_LOCK_ERROR = 3'd5,
		REG_LOST_ERROR = 3'd6,
		REG_DEFEND_PAN = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOOKUP,
		ST_SCALE,
		ST_DECIDE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SEL_PATROL,
		SEL_TARGET,
		SEL_DEFEND,
		SEL_GIMBAL
	} aim_sel_t;

	typedef struct packed {
		logic load;
		logic step1;
		logic stamp_upd;
		logic step2;
		logic step3;
		logic out_load;
		aim_sel_t out_sel;
		logic out_fire;
		mode_t out_mode;
	} tmc_cmd_t;

	typedef struct packed {
		logic is_force;
		logic [2:0] forced_mode;
		logic run;
		logic seen;
		logic range_lt;
		logic range_gt;
		logic err_lt_lock;
		logic err_gt_lock;
		logic err_gt_lost;
	} tmc_sts_t;

	typedef logic [SINE_ENTRIES-1:0][15:0] sine_tab_t;

	// Q1.15 sine from a Q30 Taylor series, evaluated at elaboration
	function automatic logic [15:0] sine_entry(input int k);
		logic [63:0] r;
		logic [63:0] quad;
		logic [63:0] q;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		r = ((64'(k) << 32) / SINE_ENTRIES) & 64'hFFFF_FFFF;
		quad = r >> 30;
		q = r & (Q30_ONE - 64'd1);
		if (quad[0])
			q = Q30_ONE - q;
		x = (q * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s = (((x * t) >> 30) + 64'd16384) >> 15;
		if (s > 64'd32767)
			s = 64'd32767;
		if (quad[1])
			s = 64'd0 - s;
		return s[15:0];
	endfunction

	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		for (int k = 0; k < SINE_ENTRIES; k++)
			tab[k] = sine_entry(k);
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

endpackage

[hdl/tmc_ctrl.sv]
module tmc_ctrl
	import tmc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input logic m_tready,
	input tmc_sts_t sts,
	output tmc_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	mode_t mode_q, mode_d;
	logic m_tvalid_q;
	logic out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_STOP;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		logic has_result;
		mode_t next_mode;
		has_result = 1'b0;
		next_mode = mode_q;
		state_d = state_q;
		mode_d = mode_q;
		cmd = '0;
		cmd.out_sel = SEL_GIMBAL;
		cmd.out_mode = mode_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				if (sts.is_force) begin
					if (sts.forced_mode <= MODE_STOP)
						mode_d = mode_t'(sts.forced_mode);
					state_d = ST_IDLE;
				end else begin
					cmd.step1 = 1'b1;
					cmd.stamp_upd = 1'b1;
					if (!sts.run) begin
						mode_d = MODE_STOP;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_LOOKUP;
					end
				end
			end
			ST_LOOKUP: begin
				cmd.step2 = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.step3 = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				case (mode_q)
					MODE_PATROL: begin
						has_result = 1'b1;
						cmd.out_sel = SEL_PATROL;
						if (sts.seen && sts.range_lt)
							next_mode = MODE_TRACK;
					end
					MODE_TRACK: begin
						if (!sts.seen) begin
							next_mode = MODE_PATROL;
						end else begin
							has_result = 1'b1;
							cmd.out_sel = SEL_TARGET;
							if (sts.err_lt_lock && sts.range_lt)
								next_mode = MODE_ATTACK;
							else if (sts.err_gt_lost)
								next_mode = MODE_PATROL;
						end
					end
					MODE_ATTACK: begin
						if (!sts.seen || sts.range_gt) begin
							next_mode = MODE_PATROL;
						end else if (sts.err_gt_lock) begin
							next_mode = MODE_TRACK;
						end else begin
							has_result = 1'b1;
							cmd.out_sel = SEL_TARGET;
							cmd.out_fire = 1'b1;
						end
					end
					MODE_DEFEND: begin
						has_result = 1'b1;
						cmd.out_sel = SEL_DEFEND;
					end
					default: begin
						has_result = 1'b1;
						next_mode = MODE_STOP;
						cmd.out_sel = SEL_GIMBAL;
					end
				endcase
				cmd.out_mode = next_mode;
				// hold a decision that has a result until the output register can take it
				if (!has_result || out_free) begin
					cmd.out_load = has_result;
					mode_d = next_mode;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/tmc_datapath.sv]
module tmc_datapath
	import tmc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic [IN_TDATA_W-1:0] s_tdata,
	input logic s_tuser,
	input tmc_cmd_t cmd,
	output tmc_sts_t sts,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	// configuration registers
	logic signed [15:0] yaw_low_q, yaw_high_q, patrol_tilt_q, defend_pan_q;
	logic [23:0] sweep_rate_q;
	logic [15:0] range_limit_q;
	logic [14:0] lock_error_q, lost_error_q;

	// run state
	logic [31:0] start_stamp_q;
	logic was_running_q;

	// captured request
	logic act_q;
	logic [2:0] fmode_q;
	logic [31:0] now_q;
	logic run_q, seen_q;
	logic [15:0] range_q;
	logic signed [15:0] tpan_q, ttilt_q, gpan_q, gtilt_q;

	// working registers
	logic [31:0] phase_q;
	logic [29:0] lock2_q, lost2_q;
	logic signed [16:0] dpan_q, dtilt_q;
	logic signed [15:0] sine_q;
	logic [33:0] sqpan_q, sqtilt_q;
	logic signed [32:0] prod_q;

	// output register
	logic signed [15:0] pan_out_q, tilt_out_q;
	logic fire_out_q;
	logic [7:0] rate_out_q;
	mode_t mode_out_q;

	logic [31:0] elapsed;
	logic [55:0] phase_full;
	logic [SINE_IDX_W-1:0] sine_idx;
	logic signed [33:0] sqpan_w, sqtilt_w;
	logic signed [16:0] span_w, sum_w;
	logic signed [32:0] prod_w;
	logic [34:0] err2;
	logic signed [34:0] num_w;
	logic signed [34:0] rnd_w;
	logic signed [18:0] shifted_w;
	logic signed [15:0] patrol_pan;
	logic signed [15:0] pan_sel, tilt_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_low_q <= -16'sd6434;
			yaw_high_q <= 16'sd6434;
			sweep_rate_q <= 24'd1073741;
			patrol_tilt_q <= '0;
			range_limit_q <= 16'd8000;
			lock_error_q <= 15'd205;
			lost_error_q <= 15'd2048;
			defend_pan_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_YAW_LOW: yaw_low_q <= cfg_data[15:0];
				REG_YAW_HIGH: yaw_high_q <= cfg_data[15:0];
				REG_SWEEP_RATE: sweep_rate_q <= cfg_data;
				REG_PATROL_TILT: patrol_tilt_q <= cfg_data[15:0];
				REG_RANGE_LIMIT: range_limit_q <= cfg_data[15:0];
				REG_LOCK_ERROR: lock_error_q <= cfg_data[14:0];
				REG_LOST_ERROR: lost_error_q <= cfg_data[14:0];
				REG_DEFEND_PAN: defend_pan_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_stamp_q <= '0;
			was_running_q <= 1'b0;
		end else if (cmd.stamp_upd) begin
			if (run_q && !was_running_q)
				start_stamp_q <= now_q;
			was_running_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tuser;
			fmode_q <= s_tdata[2:0];
			now_q <= s_tdata[34:3];
			run_q <= s_tdata[35];
			seen_q <= s_tdata[36];
			range_q <= s_tdata[52:37];
			tpan_q <= s_tdata[68:53];
			ttilt_q <= s_tdata[84:69];
			gpan_q <= s_tdata[100:85];
			gtilt_q <= s_tdata[116:101];
		end
	end

	// on a rising run enable the sweep starts at zero phase
	assign elapsed = (run_q && !was_running_q) ? '0 : now_q - start_stamp_q;
	assign phase_full = 56'(elapsed) * 56'(sweep_rate_q);
	assign sine_idx = phase_q[31 -: SINE_IDX_W];
	assign sqpan_w = dpan_q * dpan_q;
	assign sqtilt_w = dtilt_q * dtilt_q;
	assign span_w = {yaw_high_q[15], yaw_high_q} - {yaw_low_q[15], yaw_low_q};
	assign sum_w = {yaw_high_q[15], yaw_high_q} + {yaw_low_q[15], yaw_low_q};
	assign prod_w = span_w * sine_q;

	always_ff @(posedge clk) begin
		if (cmd.step1) begin
			phase_q <= phase_full[31:0];
			lock2_q <= 30'(lock_error_q) * 30'(lock_error_q);
			dpan_q <= {gpan_q[15], gpan_q} - {tpan_q[15], tpan_q};
			dtilt_q <= {gtilt_q[15], gtilt_q} - {ttilt_q[15], ttilt_q};
		end
		if (cmd.step2) begin
			sine_q <= SINE_TAB[sine_idx];
			sqpan_q <= $unsigned(sqpan_w);
			lost2_q <= 30'(lost_error_q) * 30'(lost_error_q);
		end
		if (cmd.step3) begin
			prod_q <= prod_w;
			sqtilt_q <= $unsigned(sqtilt_w);
		end
	end

	assign err2 = {1'b0, sqpan_q} + {1'b0, sqtilt_q};

	// round half up, then saturate
	assign num_w = 35'(signed'({sum_w, 15'd0})) + 35'(prod_q);
	assign rnd_w = num_w + 35'sd32768;
	assign shifted_w = 19'(rnd_w >>> 16);

	always_comb begin
		if (shifted_w > 19'sd32767)
			patrol_pan = 16'sh7FFF;
		else if (shifted_w < -19'sd32768)
			patrol_pan = 16'sh8000;
		else
			patrol_pan = shifted_w[15:0];
	end

	always_comb begin
		case (cmd.out_sel)
			SEL_PATROL: begin
				pan_sel = patrol_pan;
				tilt_sel = patrol_tilt_q;
			end
			SEL_TARGET: begin
				pan_sel = tpan_q;
				tilt_sel = ttilt_q;
			end
			SEL_DEFEND: begin
				pan_sel = defend_pan_q;
				tilt_sel = '0;
			end
			default: begin
				pan_sel = gpan_q;
				tilt_sel = gtilt_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pan_out_q <= pan_sel;
			tilt_out_q <= tilt_sel;
			fire_out_q <= cmd.out_fire;
			rate_out_q <= cmd.out_fire ? BURST_RATE : 8'd0;
			mode_out_q <= cmd.out_mode;
		end
	end

	assign m_tdata = {3'd0, fire_out_q, mode_out_q, rate_out_q, fire_out_q,
		tilt_out_q, pan_out_q};

	always_comb begin
		sts.is_force = act_q;
		sts.forced_mode = fmode_q;
		sts.run = run_q;
		sts.seen = seen_q;
		sts.range_lt = range_q < range_limit_q;
		sts.range_gt = range_q > range_limit_q;
		sts.err_lt_lock = err2 < 35'(lock2_q);
		sts.err_gt_lock = err2 > 35'(lock2_q);
		sts.err_gt_lost = err2 > 35'(lost2_q);
	end

endmodule

[hdl/turret_mode_controller_core.sv]
// control tick: a taken request passes the multiply, sine lookup, scale and decide steps in turn
// and its result is then presented from the output register; no new request is taken before decide ends
// force requests and ticks with run enable low end after the prep step and publish nothing
// a waiting result does not block the next request; the decide step holds only when it
// has a new result and the output register is still full
// reset: mode emergency stop, start stamp and run flag cleared, registers to defaults
`include "turret_mode_controller_core_defines.svh"

module turret_mode_controller_core
	import tmc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// forced_mode, now_time, run_enable, target_seen, target_range, target_pan,
	// target_tilt, gimbal_pan, gimbal_tilt, zero pad
	input logic [IN_TDATA_W-1:0] s_tdata,
	// action
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// pan_command, tilt_command, fire, shot_rate, mode, report_target, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	tmc_cmd_t cmd;
	tmc_sts_t sts;

	tmc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts(sts),
		.cmd(cmd)
	);

	tmc_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cmd(cmd),
		.sts(sts),
		.m_tdata(m_tdata)
	);

	`TMC_ASSERT_NOW(a_no_overwrite, m_tvalid && !m_tready, !cmd.out_load, "result overwritten")
	`TMC_ASSERT_NEXT(a_load_shows, cmd.out_load, m_tvalid, "loaded result not presented")
	`TMC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second request taken")
	`TMC_ASSERT_NOW(a_fire_attack, m_tvalid && m_tdata[32], m_tdata[43:41] == MODE_ATTACK,
		"fire outside attack")

endmodule

[tb/turret_mode_controller_core_test.sv]
module turret_mode_controller_core_test;
	import tmc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TABLE_SIZE = 256;
	localparam logic [7:0] SHOT_BURST_RATE = 8'd20;
	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam longint unsigned HALF_PI_FIX = 64'd1686629713;
	localparam int HOLD_OFF_CYCLES = 300;

	// input request fields, lowest bits last
	typedef struct packed {
		logic [2:0] pad;
		logic signed [15:0] gimbal_tilt;
		logic signed [15:0] gimbal_pan;
		logic signed [15:0] target_tilt;
		logic signed [15:0] target_pan;
		logic [15:0] target_range;
		logic target_seen;
		logic run_enable;
		logic [31:0] now_time;
		logic [2:0] forced_mode;
	} aim_request_t;

	typedef struct packed {
		logic report_target;
		mode_t mode;
		logic [7:0] shot_rate;
		logic fire;
		logic signed [15:0] tilt;
		logic signed [15:0] pan;
	} aim_command_t;

	typedef struct {
		logic signed [15:0] yaw_low;
		logic signed [15:0] yaw_high;
		logic [23:0] sweep_rate;
		logic signed [15:0] patrol_tilt;
		logic [15:0] range_limit;
		logic [14:0] lock_error;
		logic [14:0] lost_error;
		logic signed [15:0] defend_pan;
	} turret_settings_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	turret_settings_t cur_set = '{-16'sd6434, 16'sd6434, 24'd1073741, 16'sd0, 16'd8000,
		15'd205, 15'd2048, 16'sd0};
	mode_t ctl_mode = MODE_STOP;
	logic [31:0] run_stamp = '0;
	logic was_enabled = 1'b0;
	shortint sweep_sine [TABLE_SIZE];
	aim_command_t pending_commands [$];
	logic [31:0] clock_ms = '0;
	int fault_count = 0;
	int cycle_count = 0;
	bit sender_gaps = 1'b1;
	int hold_request = 0;
	bit receiver_holding = 1'b0;

	turret_mode_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// q1.15 sine of a table step via a q30 taylor series
	function automatic shortint taylor_sine(input int k);
		longint unsigned turn, frac, x, x2, t, s;
		int divisors [5] = '{110, 72, 42, 20, 6};
		turn = ((64'(k) << 32) / TABLE_SIZE) & 64'hFFFF_FFFF;
		frac = turn & (Q30 - 1);
		if (turn[30])
			frac = Q30 - frac;
		x = (frac * HALF_PI_FIX) >> 30;
		x2 = (x * x) >> 30;
		t = Q30;
		foreach (divisors[i])
			t = Q30 - ((x2 * t) >> 30) / divisors[i];
		s = (((x * t) >> 30) + 16384) >> 15;
		if (s > 32767)
			s = 32767;
		return turn[31] ? -shortint'(s) : shortint'(s);
	endfunction

	function automatic logic signed [15:0] sweep_pan(input logic [31:0] now);
		logic [31:0] elapsed, phase;
		longint unsigned idx;
		longint hi, lo, num, pan;
		elapsed = now - run_stamp;
		phase = 32'(64'(elapsed) * 64'(cur_set.sweep_rate));
		idx = (64'(phase) * TABLE_SIZE) >> 32;
		if (idx >= TABLE_SIZE)
			idx = TABLE_SIZE - 1;
		hi = cur_set.yaw_high;
		lo = cur_set.yaw_low;
		num = (hi + lo) * 32768 + (hi - lo) * sweep_sine[idx];
		// round half up, floor division by 2^16
		pan = (num + 32768) >>> 16;
		if (pan > 32767)
			pan = 32767;
		else if (pan < -32768)
			pan = -32768;
		return pan[15:0];
	endfunction

	function automatic bit advance_controller(input logic act, input aim_request_t rq,
			output aim_command_t cmd);
		longint dp, dt, err2, lock2, lost2;
		cmd = '0;
		if (act) begin
			if (rq.forced_mode <= MODE_STOP)
				ctl_mode = mode_t'(rq.forced_mode);
			return 1'b0;
		end
		if (rq.run_enable && !was_enabled)
			run_stamp = rq.now_time;
		was_enabled = rq.run_enable;
		if (!rq.run_enable) begin
			ctl_mode = MODE_STOP;
			return 1'b0;
		end
		dp = longint'(rq.gimbal_pan) - longint'(rq.target_pan);
		dt = longint'(rq.gimbal_tilt) - longint'(rq.target_tilt);
		err2 = dp * dp + dt * dt;
		lock2 = longint'(cur_set.lock_error) * longint'(cur_set.lock_error);
		lost2 = longint'(cur_set.lost_error) * longint'(cur_set.lost_error);
		case (ctl_mode)
			MODE_PATROL: begin
				cmd.pan = sweep_pan(rq.now_time);
				cmd.tilt = cur_set.patrol_tilt;
				if (rq.target_seen && rq.target_range < cur_set.range_limit)
					ctl_mode = MODE_TRACK;
			end
			MODE_TRACK: begin
				if (!rq.target_seen) begin
					ctl_mode = MODE_PATROL;
					return 1'b0;
				end
				cmd.pan = rq.target_pan;
				cmd.tilt = rq.target_tilt;
				if (err2 < lock2 && rq.target_range < cur_set.range_limit)
					ctl_mode = MODE_ATTACK;
				else if (err2 > lost2)
					ctl_mode = MODE_PATROL;
			end
			MODE_ATTACK: begin
				if (!rq.target_seen || rq.target_range > cur_set.range_limit) begin
					ctl_mode = MODE_PATROL;
					return 1'b0;
				end
				if (err2 > lock2) begin
					ctl_mode = MODE_TRACK;
					return 1'b0;
				end
				cmd.pan = rq.target_pan;
				cmd.tilt = rq.target_tilt;
				cmd.fire = 1'b1;
				cmd.shot_rate = SHOT_BURST_RATE;
				cmd.report_target = 1'b1;
			end
			MODE_DEFEND: begin
				cmd.pan = cur_set.defend_pan;
				cmd.tilt = '0;
			end
			default: begin
				ctl_mode = MODE_STOP;
				cmd.pan = rq.gimbal_pan;
				cmd.tilt = rq.gimbal_tilt;
			end
		endcase
		cmd.mode = ctl_mode;
		return 1'b1;
	endfunction

	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int spread(input int limit);
		return int'($urandom_range(0, 2 * limit)) - limit;
	endfunction

	// mostly aimed near the lock and lost thresholds so the mode machine moves
	function automatic aim_request_t random_tick();
		aim_request_t rq;
		int roll, lim, lk, lt, dp, dt;
		rq = '0;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			clock_ms = $urandom;
		else if (roll < 25)
			clock_ms += $urandom_range(100, 5000);
		else
			clock_ms += $urandom_range(0, 3);
		rq.now_time = clock_ms;
		rq.run_enable = $urandom_range(0, 199) >= 3;
		rq.target_seen = $urandom_range(0, 9) != 0;
		lim = cur_set.range_limit;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			rq.target_range = (lim == 0) ? 16'd0 : 16'($urandom_range(0, lim - 1));
		else if (roll == 7)
			rq.target_range = 16'(lim);
		else if (roll == 8)
			rq.target_range = (lim == 65535) ? 16'(lim) : 16'(lim + 1);
		else
			rq.target_range = 16'($urandom);
		rq.target_pan = 16'($urandom);
		rq.target_tilt = 16'($urandom);
		lk = cur_set.lock_error;
		lt = cur_set.lost_error;
		dp = 0;
		dt = 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				dp = spread(lk / 2);
				dt = spread(lk / 2);
			end
			4: dp = lk;
			5: dt = lt;
			6: dp = lk + int'($urandom_range(0, (lt > lk) ? lt - lk : 0));
			7: dp = lt + 1;
			default: begin
				dp = int'($urandom_range(0, 65535));
				dt = int'($urandom_range(0, 65535));
			end
		endcase
		if ($urandom_range(0, 1))
			dp = -dp;
		rq.gimbal_pan = 16'(int'(rq.target_pan) + dp);
		rq.gimbal_tilt = 16'(int'(rq.target_tilt) + dt);
		rq.forced_mode = 3'($urandom);
		return rq;
	endfunction

	function automatic turret_settings_t random_settings();
		turret_settings_t cfg;
		cfg.yaw_low = 16'($urandom);
		cfg.yaw_high = 16'($urandom);
		cfg.sweep_rate = 24'($urandom) >> $urandom_range(0, 12);
		cfg.patrol_tilt = 16'($urandom);
		cfg.range_limit = 16'($urandom_range(0, 20000));
		cfg.lock_error = 15'($urandom_range(0, 3000));
		if ($urandom_range(0, 3) == 0)
			cfg.lost_error = 15'($urandom_range(0, cfg.lock_error));
		else
			cfg.lost_error = cfg.lock_error + 15'($urandom_range(0, 8000));
		cfg.defend_pan = 16'($urandom);
		return cfg;
	endfunction

	task automatic log_fault(input string msg);
		if (fault_count < 40)
			$display("mismatch: %s", msg);
		fault_count++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			log_fault($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic send_request(input logic act, input aim_request_t rq);
		aim_command_t cmd;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= rq;
		do @(posedge clk); while (!s_tready);
		if (advance_controller(act, rq, cmd))
			pending_commands.push_back(cmd);
		gap = sender_gaps ? idle_length() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tick(input logic run, input logic [31:0] now, input logic seen,
			input logic [15:0] range, input int tp, input int tt, input int gp, input int gt);
		aim_request_t rq;
		rq = '0;
		rq.run_enable = run;
		rq.now_time = now;
		rq.target_seen = seen;
		rq.target_range = range;
		rq.target_pan = 16'(tp);
		rq.target_tilt = 16'(tt);
		rq.gimbal_pan = 16'(gp);
		rq.gimbal_tilt = 16'(gt);
		rq.forced_mode = 3'($urandom);
		send_request(1'b0, rq);
	endtask

	task automatic send_force(input logic [2:0] m);
		aim_request_t rq;
		rq = random_tick();
		rq.forced_mode = m;
		send_request(1'b1, rq);
	endtask

	task automatic send_random();
		aim_request_t rq;
		rq = random_tick();
		if ($urandom_range(0, 99) < 10) begin
			if ($urandom_range(0, 99) < 60)
				rq.forced_mode = 3'($urandom_range(MODE_PATROL, MODE_ATTACK));
			send_request(1'b1, rq);
		end else begin
			send_request(1'b0, rq);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_commands.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// unused upper data bits carry junk, the block must ignore them
	task automatic apply_settings(input turret_settings_t cfg);
		write_reg(REG_YAW_LOW, {8'($urandom), cfg.yaw_low});
		write_reg(REG_YAW_HIGH, {8'($urandom), cfg.yaw_high});
		write_reg(REG_SWEEP_RATE, cfg.sweep_rate);
		write_reg(REG_PATROL_TILT, {8'($urandom), cfg.patrol_tilt});
		write_reg(REG_RANGE_LIMIT, {8'($urandom), cfg.range_limit});
		write_reg(REG_LOCK_ERROR, {9'($urandom), cfg.lock_error});
		write_reg(REG_LOST_ERROR, {9'($urandom), cfg.lost_error});
		write_reg(REG_DEFEND_PAN, {8'($urandom), cfg.defend_pan});
		cfg_wen <= 1'b0;
		cur_set = cfg;
	endtask

	task automatic test_directed_modes();
		send_tick(1'b0, 32'd100, 1'b1, 16'd50, 0, 0, 1234, -1234);
		// run rises: stamp taken, stop echoes the gimbal
		send_tick(1'b1, 32'd0, 1'b0, 16'd0, 0, 0, -32768, 32767);
		send_tick(1'b1, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 32767, -32768, 32767, -32768);
		send_force(MODE_PATROL);
		send_tick(1'b1, 32'd5000, 1'b0, 16'd0, 0, 0, 0, 0);
		// range equal to the limit is not close enough
		send_tick(1'b1, 32'd12000, 1'b1, 16'd8000, 0, 0, 0, 0);
		send_tick(1'b1, 32'd20000, 1'b1, 16'd100, 1000, -500, -30000, 30000);
		send_tick(1'b1, 32'd20001, 1'b1, 16'd100, 1000, -500, -30000, 30000);
		send_tick(1'b1, 32'd20002, 1'b1, 16'd0, 0, 0, 0, 0);
		// error exactly at lock, then exactly at lost: track holds
		send_tick(1'b1, 32'd20003, 1'b1, 16'd100, 300, 300, 505, 300);
		send_tick(1'b1, 32'd20004, 1'b1, 16'd100, 300, 300, 300, 2348);
		send_tick(1'b1, 32'd20005, 1'b1, 16'd7999, -32768, 32767, -32758, 32757);
		// attack still fires with range and error both at their limits, then drops to track just past lock
		send_tick(1'b1, 32'd20006, 1'b1, 16'd8000, 100, 100, 305, 100);
		send_tick(1'b1, 32'd20007, 1'b1, 16'd10, 100, 100, 306, 100);
		send_tick(1'b1, 32'd20008, 1'b1, 16'd5, 7, 7, 7, 7);
		send_tick(1'b1, 32'd20009, 1'b0, 16'd5, 7, 7, 7, 7);
		send_tick(1'b1, 32'd20010, 1'b1, 16'd1, 7, 7, 7, 7);
		send_tick(1'b1, 32'd20011, 1'b0, 16'd1, 7, 7, 7, 7);
		for (int m = MODE_STOP + 1; m < 8; m++)
			send_force(3'(m));
		send_force(MODE_DEFEND);
		send_tick(1'b1, 32'd20012, 1'b1, 16'd1, 7, 7, 7, 7);
		send_force(MODE_ATTACK);
		send_tick(1'b1, 32'd20013, 1'b1, 16'd8001, 7, 7, 7, 7);
		send_force(MODE_STOP);
		send_tick(1'b0, 32'd500, 1'b1, 16'd1, 7, 7, 7, 7);
		send_tick(1'b1, 32'd777, 1'b1, 16'd1, 7, 7, -5, 5);
		send_force(MODE_PATROL);
		send_tick(1'b1, 32'd2777, 1'b0, 16'd1, 7, 7, 7, 7);
		drain();
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) send_random();
		drain();
	endtask

	task automatic test_setting_extremes();
		apply_settings('{16'sh8000, 16'sh7FFF, 24'hFF_FFFF, 16'sh7FFF, 16'hFFFF, 15'h7FFF,
			15'h7FFF, 16'sh8000});
		test_random_traffic(60);
		apply_settings('{16'sh7FFF, 16'sh8000, 24'd0, 16'sh8000, 16'd0, 15'd0, 15'd0,
			16'sh7FFF});
		test_random_traffic(60);
	endtask

	task automatic test_random_settings();
		repeat (2) begin
			apply_settings(random_settings());
			test_random_traffic(70);
		end
		// back to back requests with no sender gaps
		apply_settings(random_settings());
		sender_gaps = 1'b0;
		test_random_traffic(70);
		sender_gaps = 1'b1;
	endtask

	// receiver stalls for a long stretch while requests keep coming
	task automatic test_backpressure();
		aim_request_t rq;
		send_force(MODE_STOP);
		sender_gaps = 1'b0;
		hold_request = HOLD_OFF_CYCLES;
		while (!receiver_holding)
			@(posedge clk);
		repeat (40) begin
			rq = random_tick();
			rq.run_enable = 1'b1;
			send_request(1'b0, rq);
		end
		sender_gaps = 1'b1;
		drain();
	endtask

	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				m_tready <= 1'b0;
				receiver_holding = 1'b1;
				repeat (n) @(posedge clk);
				receiver_holding = 1'b0;
			end else begin
				n = idle_length();
				if (n == 0) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 16)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		aim_command_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[44:0];
			if (pending_commands.size() == 0) begin
				log_fault($sformatf("command %h with none pending", m_tdata));
			end else begin
				want = pending_commands.pop_front();
				check_field("pan_command", got.pan, want.pan);
				check_field("tilt_command", got.tilt, want.tilt);
				check_field("fire", got.fire, want.fire);
				check_field("shot_rate", got.shot_rate, want.shot_rate);
				check_field("mode", got.mode, want.mode);
				check_field("report_target", got.report_target, want.report_target);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < TABLE_SIZE; k++)
			sweep_sine[k] = taylor_sine(k);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_modes();
		test_random_traffic(100);
		test_setting_extremes();
		test_random_settings();
		test_backpressure();
		drain();
		if (fault_count == 0 && pending_commands.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
